>>> hdl/u2u_pkg.sv
package u2u_pkg;

  localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
  localparam logic [20:0] MAX_CP       = 21'h10FFFF;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;

  localparam logic [7:0] ASCII_TOP  = 8'h7F;
  localparam logic [7:0] LEAD_MIN   = 8'hC0;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MAX  = 8'hF7;

  // one utf-16 result unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_replacement;
    logic        last_of_item;
    logic        text_done;
  } unit_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0] count;
    unit_t      unit0;
    unit_t      unit1;
  } res_pair_t;

endpackage

>>> hdl/utf8_to_utf16_transcoder.sv
// channel  | dir | tdata                     | tuser                                | tlast
// s_axis   | in  | [7:0] data_byte           | -                                    | end_of_text
// m_axis   | out | [15:0] code_unit          | [0] is_replacement, [1] last_of_item | text_done
//
// one byte a cycle while the result buffer has room: a byte waits in the input register, then is decoded into
// 0, 1 or 2 units in a single pass and loaded into the two-entry result buffer
// the output drains one unit a cycle while m_axis_tready is high, so a surrogate pair byte
// holds the output for both its units; that buffer sets the rate when pairs come in a row
// reset clears decode state and both valid flags, no sweep needed
// output stalls back up through the buffer into the input register
module utf8_to_utf16_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic [1:0]  m_axis_tuser,   // [0] is_replacement, [1] last_of_item
  output logic        m_axis_tlast    // text_done
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;

  logic               buf_free;
  logic               move;      // byte leaves input register into the result buffer
  u2u_pkg::res_pair_t pair;

  assign move          = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  // decode state advances only when the byte's results are taken by the buffer
  u2u_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (move),
    .data_byte_i   (in_byte_q),
    .end_of_text_i (in_eot_q),
    .pair_o        (pair)
  );

  // holds the units of one byte and presents them one beat at a time
  u2u_result_buf u_result_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (move),
    .pair_i        (pair),
    .free_o        (buf_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> hdl/u2u_decoder.sv
module u2u_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               commit_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_text_i,
  output u2u_pkg::res_pair_t pair_o
);

  logic [20:0] pc_q, pc_d;
  logic [1:0]  rem_q, rem_d;
  logic        skip_q, skip_d;

  logic        cont;
  logic [20:0] pc_shift;
  logic [19:0] supp_off;
  logic        lead_en;
  logic [1:0]  n;
  logic [15:0] code [2];
  logic        repl [2];

  assign cont     = (data_byte_i[7:6] == 2'b10);
  assign pc_shift = {pc_q[14:0], data_byte_i[5:0]};
  assign supp_off = 20'(pc_shift - u2u_pkg::SUPP_BASE);

  always_comb begin
    pc_d    = pc_q;
    rem_d   = rem_q;
    skip_d  = skip_q;
    lead_en = 1'b0;
    n       = 2'd0;
    code[0] = '0;
    code[1] = '0;
    repl[0] = 1'b0;
    repl[1] = 1'b0;

    if (rem_q != 2'd0) begin
      if (cont) begin
        pc_d  = pc_shift;
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          pc_d = '0;
          if (pc_shift > u2u_pkg::MAX_CP) begin
            code[n[0]] = u2u_pkg::REPL_UNIT;
            repl[n[0]] = 1'b1;
            n          = n + 2'd1;
            skip_d     = 1'b1;
          end else if (pc_shift[20:16] != 5'd0) begin
            // supplementary plane: surrogate pair
            code[0] = u2u_pkg::HI_SURR_BASE + {6'd0, supp_off[19:10]};
            code[1] = u2u_pkg::LO_SURR_BASE + {6'd0, supp_off[9:0]};
            n       = 2'd2;
          end else begin
            code[n[0]] = pc_shift[15:0];
            n          = n + 2'd1;
          end
        end
      end else begin
        // broken sequence, byte is then taken as a new lead
        code[n[0]] = u2u_pkg::REPL_UNIT;
        repl[n[0]] = 1'b1;
        n          = n + 2'd1;
        rem_d      = 2'd0;
        pc_d       = '0;
        lead_en    = 1'b1;
      end
    end else if (!(skip_q && cont)) begin
      skip_d  = 1'b0;
      lead_en = 1'b1;
    end

    if (lead_en) begin
      if (data_byte_i <= u2u_pkg::ASCII_TOP) begin
        code[n[0]] = {8'd0, data_byte_i};
        n          = n + 2'd1;
      end else if (data_byte_i < u2u_pkg::LEAD_MIN || data_byte_i > u2u_pkg::LEAD4_MAX) begin
        code[n[0]] = u2u_pkg::REPL_UNIT;
        repl[n[0]] = 1'b1;
        n          = n + 2'd1;
        skip_d     = 1'b1;
      end else if (data_byte_i <= u2u_pkg::LEAD2_MAX) begin
        pc_d  = {16'd0, data_byte_i[4:0]};
        rem_d = 2'd1;
      end else if (data_byte_i <= u2u_pkg::LEAD3_MAX) begin
        pc_d  = {17'd0, data_byte_i[3:0]};
        rem_d = 2'd2;
      end else begin
        pc_d  = {18'd0, data_byte_i[2:0]};
        rem_d = 2'd3;
      end
    end

    if (end_of_text_i) begin
      // cut off sequence
      if (rem_d != 2'd0) begin
        code[n[0]] = u2u_pkg::REPL_UNIT;
        repl[n[0]] = 1'b1;
        n          = n + 2'd1;
      end
      pc_d   = '0;
      rem_d  = 2'd0;
      skip_d = 1'b0;
    end

    pair_o.count                = n;
    pair_o.unit0.code_unit      = code[0];
    pair_o.unit0.is_replacement = repl[0];
    pair_o.unit0.last_of_item   = (n == 2'd1);
    pair_o.unit0.text_done      = (n == 2'd1) && end_of_text_i;
    pair_o.unit1.code_unit      = code[1];
    pair_o.unit1.is_replacement = repl[1];
    pair_o.unit1.last_of_item   = (n == 2'd2);
    pair_o.unit1.text_done      = (n == 2'd2) && end_of_text_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      rem_q  <= '0;
      skip_q <= 1'b0;
    end else if (commit_i) begin
      pc_q   <= pc_d;
      rem_q  <= rem_d;
      skip_q <= skip_d;
    end
  end

endmodule

>>> hdl/u2u_result_buf.sv
module u2u_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  u2u_pkg::res_pair_t pair_i,
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  logic [1:0]     cnt_q;
  u2u_pkg::unit_t ent_q [2];
  logic           pop;

  assign pop           = (cnt_q != 2'd0) && m_axis_tready;
  assign free_o        = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = ent_q[0].code_unit;
  assign m_axis_tuser  = {ent_q[0].last_of_item, ent_q[0].is_replacement};
  assign m_axis_tlast  = ent_q[0].text_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= pair_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q[0] <= pair_i.unit0;
      ent_q[1] <= pair_i.unit1;
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
    end
  end

endmodule

>>> hdl/u2u_checker.sv
module u2u_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // replacement beats always carry fffd
  a_repl_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == u2u_pkg::REPL_UNIT)
    else $error("replacement beat without fffd");

  // text end only on the last unit of a byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("text_done without last_of_item");

  // a non-final unit is a replacement or a high surrogate
  a_first_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |->
      (m_axis_tuser[0] || m_axis_tdata[15:10] == 6'b110110))
    else $error("unexpected first unit of a pair");

  // a high surrogate beat is followed by a low surrogate beat
  a_low_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser[1] && !m_axis_tuser[0] |=>
      m_axis_tvalid && m_axis_tdata[15:10] == 6'b110111)
    else $error("high surrogate not followed by low surrogate");

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

endmodule

bind utf8_to_utf16_transcoder u2u_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/utf8_to_utf16_transcoder_tb.sv
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_tb;

  localparam int PREDICT      = -1;    // row checked against the decoder model
  localparam int RANDOM_BYTES = 1880;
  localparam int LONG_HOLD    = 500;   // output held off once, input must back up
  localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 20;

  // directed stimulus row: a byte, its end-of-text flag and, where obvious,
  // the unit it must give (n_typed 0 or 1), else PREDICT
  typedef struct {
    logic [7:0]     data_byte;
    logic           end_of_text;
    int             n_typed;
    u2u_pkg::unit_t typed_unit;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;    // end_of_text
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [15:0] code_unit
  logic [1:0] m_axis_tuser;           // [0] is_replacement, [1] last_of_item
  logic       m_axis_tlast;           // text_done

  // decoder model state
  logic [20:0]    cp_acc;
  logic [1:0]     conts_left;
  logic [2:0]     seq_len;
  logic           discarding;
  u2u_pkg::unit_t decoded [2];
  int             n_decoded;

  u2u_pkg::unit_t expected_units [$];
  stim_row_t      directed_rows [$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  texts_sent = 0;
  int  units_checked = 0;
  int  repl_seen = 0;
  int  surrogates_seen = 0;
  int  idle_cycles = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  hold_off_req = 1'b0;

  utf8_to_utf16_transcoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic u2u_pkg::unit_t mk_unit(input logic [15:0] cu, input logic repl,
                                             input logic last, input logic done);
    u2u_pkg::unit_t u;
    u.code_unit      = cu;
    u.is_replacement = repl;
    u.last_of_item   = last;
    u.text_done      = done;
    return u;
  endfunction

  // at most two units per byte, anything beyond is dropped
  task automatic emit_unit(input logic [15:0] cu, input logic repl);
    if (n_decoded < 2) begin
      decoded[n_decoded] = mk_unit(cu, repl, 1'b0, 1'b0);
      n_decoded++;
    end
  endtask

  task automatic start_lead(input logic [7:0] b);
    if (b <= u2u_pkg::ASCII_TOP) begin
      emit_unit({8'h00, b}, 1'b0);
    end else if (b < u2u_pkg::LEAD_MIN || b > u2u_pkg::LEAD4_MAX) begin
      // stray continuation or lead f8-ff
      emit_unit(u2u_pkg::REPL_UNIT, 1'b1);
      discarding = 1'b1;
    end else if (b <= u2u_pkg::LEAD2_MAX) begin
      cp_acc = {16'b0, b[4:0]};
      conts_left = 2'd1;
      seq_len = 3'd2;
    end else if (b <= u2u_pkg::LEAD3_MAX) begin
      cp_acc = {17'b0, b[3:0]};
      conts_left = 2'd2;
      seq_len = 3'd3;
    end else begin
      cp_acc = {18'b0, b[2:0]};
      conts_left = 2'd3;
      seq_len = 3'd4;
    end
  endtask

  task automatic clear_decoder();
    cp_acc = '0;
    conts_left = '0;
    seq_len = '0;
    discarding = 1'b0;
  endtask

  // fills decoded[] with the units one accepted byte gives
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic        is_cont;
    logic [20:0] supp;
    is_cont = (b[7:6] == 2'b10);
    n_decoded = 0;
    if (conts_left != 0) begin
      if (is_cont) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        conts_left--;
        if (conts_left == 0) begin
          seq_len = '0;
          if (cp_acc > u2u_pkg::MAX_CP) begin
            emit_unit(u2u_pkg::REPL_UNIT, 1'b1);
            discarding = 1'b1;
          end else if (cp_acc >= u2u_pkg::SUPP_BASE) begin
            supp = cp_acc - u2u_pkg::SUPP_BASE;
            emit_unit(u2u_pkg::HI_SURR_BASE + {6'b0, supp[19:10]}, 1'b0);
            emit_unit(u2u_pkg::LO_SURR_BASE + {6'b0, supp[9:0]}, 1'b0);
          end else begin
            emit_unit(cp_acc[15:0], 1'b0);
          end
          cp_acc = '0;
        end
      end else begin
        // broken sequence, the byte is then taken as a new lead
        emit_unit(u2u_pkg::REPL_UNIT, 1'b1);
        cp_acc = '0;
        conts_left = '0;
        seq_len = '0;
        start_lead(b);
      end
    end else if (!(discarding && is_cont)) begin
      discarding = 1'b0;
      start_lead(b);
    end
    if (eot) begin
      // text cut off inside a sequence
      if (conts_left != 0) emit_unit(u2u_pkg::REPL_UNIT, 1'b1);
      clear_decoder();
    end
    if (n_decoded > 0) begin
      decoded[n_decoded-1].last_of_item = 1'b1;
      decoded[n_decoded-1].text_done = eot;
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic eot, input int n_typed,
                         input u2u_pkg::unit_t typed);
    stim_row_t r;
    r.data_byte   = b;
    r.end_of_text = eot;
    r.n_typed     = n_typed;
    r.typed_unit  = typed;
    directed_rows.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eot, input int n_typed,
                           input u2u_pkg::unit_t typed);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // beat taken at this edge
    decode_byte(b, eot);
    if (n_typed == PREDICT) begin
      for (int i = 0; i < n_decoded; i++) expected_units.push_back(decoded[i]);
    end else if (n_typed == 1) begin
      expected_units.push_back(typed);
    end
    bytes_sent++;
    if (eot) texts_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // output side: random hold-offs per beat, one long hold on request
  initial begin : sink
    int w;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        w = LONG_HOLD;
      end else begin
        w = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if ($urandom_range(0, 59) == 0) rx_burst = !rx_burst;
    end
  end

  // every output beat against the oldest expected unit
  always @(posedge clk_i) begin : check_units
    u2u_pkg::unit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      units_checked++;
      if (m_axis_tuser[0]) repl_seen++;
      else if (m_axis_tdata[15:11] == 5'b11011) surrogates_seen++;
      if (expected_units.size() == 0) begin
        $error("unexpected unit %h, nothing pending", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_units.pop_front();
        if (m_axis_tdata !== want.code_unit) begin
          $error("code_unit: expected %h, got %h", want.code_unit, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.is_replacement) begin
          $error("is_replacement: expected %b, got %b", want.is_replacement, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.last_of_item) begin
          $error("last_of_item: expected %b, got %b", want.last_of_item, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tlast !== want.text_done) begin
          $error("text_done: expected %b, got %b", want.text_done, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] seq_bytes [$];
    int         kind;
    int         len;
    int         keep;
    int         random_bytes;
    bit         hold_done;
    logic       eot;

    random_bytes = 0;
    hold_done = 1'b0;
    clear_decoder();

    // ascii extremes after reset
    add_row(8'h00, 1'b0, 1, mk_unit(16'h0000, 1'b0, 1'b1, 1'b0));
    add_row(8'h7F, 1'b1, 1, mk_unit(16'h007F, 1'b0, 1'b1, 1'b1));
    // two-byte sequence
    add_row(8'hC2, 1'b0, PREDICT, '0);
    add_row(8'hA9, 1'b0, PREDICT, '0);
    // four-byte sequence, surrogate pair
    add_row(8'hF0, 1'b0, PREDICT, '0);
    add_row(8'h9F, 1'b0, PREDICT, '0);
    add_row(8'h98, 1'b0, PREDICT, '0);
    add_row(8'h80, 1'b0, PREDICT, '0);
    // ffff stays a single unit
    add_row(8'hEF, 1'b0, PREDICT, '0);
    add_row(8'hBF, 1'b0, PREDICT, '0);
    add_row(8'hBF, 1'b0, PREDICT, '0);
    // encoded fffd is not a replacement
    add_row(8'hEF, 1'b0, PREDICT, '0);
    add_row(8'hBF, 1'b0, PREDICT, '0);
    add_row(8'hBD, 1'b0, PREDICT, '0);
    // stray continuation, then one dropped while skipping
    add_row(8'h80, 1'b0, 1, mk_unit(u2u_pkg::REPL_UNIT, 1'b1, 1'b1, 1'b0));
    add_row(8'hBF, 1'b0, 0, '0);
    // invalid lead
    add_row(8'hFF, 1'b0, 1, mk_unit(u2u_pkg::REPL_UNIT, 1'b1, 1'b1, 1'b0));
    // 110000 is past the top of the code space
    add_row(8'hF4, 1'b0, PREDICT, '0);
    add_row(8'h90, 1'b0, PREDICT, '0);
    add_row(8'h80, 1'b0, PREDICT, '0);
    add_row(8'h80, 1'b0, PREDICT, '0);
    // broken sequence gives two units in one step
    add_row(8'hE2, 1'b0, PREDICT, '0);
    add_row(8'h41, 1'b0, PREDICT, '0);
    // broken, then cut off by end of text
    add_row(8'hE2, 1'b0, PREDICT, '0);
    add_row(8'hC3, 1'b1, PREDICT, '0);
    // end of text on a dropped continuation gives nothing
    add_row(8'hF8, 1'b0, 1, mk_unit(u2u_pkg::REPL_UNIT, 1'b1, 1'b1, 1'b0));
    add_row(8'h80, 1'b1, 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data_byte, directed_rows[i].end_of_text,
                directed_rows[i].n_typed, directed_rows[i].typed_unit);
    end

    // random part: mostly well-formed sequences, some cut short, some noise
    while (random_bytes < RANDOM_BYTES) begin
      seq_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        seq_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 85) begin
        len = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
        if (kind >= 75) len = $urandom_range(2, 4);
        keep = (kind >= 75) ? $urandom_range(1, len - 1) : len;
        case (len)
          2: seq_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          3: seq_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          default: seq_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
        endcase
        repeat (keep - 1) seq_bytes.push_back(cont_byte());
      end else begin
        seq_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      if (!hold_done && random_bytes >= 900) begin
        // long output hold while input keeps coming back to back
        hold_done = 1'b1;
        tx_burst = 1'b1;
        hold_off_req = 1'b1;
      end
      foreach (seq_bytes[i]) begin
        eot = ($urandom_range(0, 15) == 0);
        send_byte(seq_bytes[i], eot, PREDICT, '0);
        random_bytes++;
      end
    end
    // close the last text
    send_byte(8'h2E, 1'b1, PREDICT, '0);
    s_axis_tvalid <= 1'b0;

    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d bytes in %0d texts, %0d directed rows and one long output hold",
             bytes_sent, texts_sent, directed_rows.size());
    $display("checked %0d units: %0d replacements, %0d surrogate halves",
             units_checked, repl_seen, surrogates_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
